// ===== design/cube_map_face_and_uv_select_core_defines.svh =====
// Assertion macros shared by the cube map face select design.
`ifndef CUBE_MAP_FACE_AND_UV_SELECT_CORE_DEFINES_SVH
`define CUBE_MAP_FACE_AND_UV_SELECT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CMF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define CMF_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define CMF_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CMF_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// ===== design/cmf_pkg.sv =====
package cmf_pkg;

  localparam int CMF_COMP_BITS  = 16;
  localparam int CMF_COORD_BITS = 16;
  localparam int FACE_BITS      = 3;

  localparam logic [FACE_BITS-1:0] FACE_POS_X = 3'd0;
  localparam logic [FACE_BITS-1:0] FACE_NEG_X = 3'd1;
  localparam logic [FACE_BITS-1:0] FACE_POS_Y = 3'd2;
  localparam logic [FACE_BITS-1:0] FACE_NEG_Y = 3'd3;
  localparam logic [FACE_BITS-1:0] FACE_POS_Z = 3'd4;
  localparam logic [FACE_BITS-1:0] FACE_NEG_Z = 3'd5;

  typedef enum logic [1:0] {
    MODE_DIV  = 2'b00,
    MODE_ZERO = 2'b01,
    MODE_MAX  = 2'b10
  } coord_mode_t;

  typedef struct packed {
    logic                 valid;
    logic [FACE_BITS-1:0] face;
    logic                 degenerate;
    coord_mode_t          u_mode;
    coord_mode_t          v_mode;
  } cmf_ctl_t;

endpackage

// ===== design/cmf_front.sv =====
module cmf_front import cmf_pkg::*; #(
  parameter int COMP_BITS  = CMF_COMP_BITS,
  parameter int COORD_BITS = CMF_COORD_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [COMP_BITS-1:0]           dir_x,
  input  logic signed [COMP_BITS-1:0]           dir_y,
  input  logic signed [COMP_BITS-1:0]           dir_z,
  output cmf_ctl_t                              ctl,
  output logic [COMP_BITS:0]                    den2,
  output logic [1:0][COMP_BITS:0]               rem,
  output logic [1:0][COORD_BITS-1:0]            quo
);

  localparam int EW = COMP_BITS + 1;
  localparam int AW = COMP_BITS + 2;

  logic signed [EW-1:0] xe, ye, ze;
  logic [EW-1:0]        ax, ay, az;
  logic signed [EW-1:0] m;
  logic signed [EW-1:0] den;
  logic signed [EW-1:0] n [2];
  logic signed [EW-1:0] num [2];
  logic signed [AW-1:0] asum [2];
  logic [EW-1:0]        d;
  logic                 m_neg, m_zero;
  cmf_ctl_t             ctl_next;
  logic [1:0][EW-1:0]   rem_next;

  always_comb begin
    xe = EW'(dir_x);
    ye = EW'(dir_y);
    ze = EW'(dir_z);
    ax = xe[EW-1] ? EW'(-xe) : xe;
    ay = ye[EW-1] ? EW'(-ye) : ye;
    az = ze[EW-1] ? EW'(-ze) : ze;

    ctl_next       = '0;
    ctl_next.valid = in_valid;
    if (ax >= ay && ax >= az) begin
      m = xe;
      if (!xe[EW-1] && xe != '0) begin
        ctl_next.face = FACE_POS_X; n[0] = -ze; n[1] = -ye;
      end else begin
        ctl_next.face = FACE_NEG_X; n[0] = -ze; n[1] = ye;
      end
    end else if (ay >= az) begin
      m = ye;
      if (!ye[EW-1] && ye != '0) begin
        ctl_next.face = FACE_POS_Y; n[0] = xe; n[1] = ze;
      end else begin
        ctl_next.face = FACE_NEG_Y; n[0] = -xe; n[1] = ze;
      end
    end else begin
      m = ze;
      if (!ze[EW-1] && ze != '0) begin
        ctl_next.face = FACE_POS_Z; n[0] = xe; n[1] = -ye;
      end else begin
        ctl_next.face = FACE_NEG_Z; n[0] = xe; n[1] = ye;
      end
    end

    m_neg  = m[EW-1];
    m_zero = (m == '0);
    ctl_next.degenerate = m_zero;
    den = m_neg ? -m : m;
    // den is at most half the full range, so doubling fits one extra bit
    d   = {den[EW-2:0], 1'b0};

    for (int i = 0; i < 2; i++) begin
      num[i]  = m_neg ? -n[i] : n[i];
      asum[i] = AW'(num[i]) + AW'(den);
      rem_next[i] = asum[i][EW-1:0];
    end

    ctl_next.u_mode = MODE_DIV;
    ctl_next.v_mode = MODE_DIV;
    if (m_zero || asum[0][AW-1] || asum[0] == '0) begin
      ctl_next.u_mode = MODE_ZERO;
      rem_next[0]     = '0;
    end else if (asum[0][EW-1:0] >= d) begin
      ctl_next.u_mode = MODE_MAX;
    end
    if (m_zero || asum[1][AW-1] || asum[1] == '0) begin
      ctl_next.v_mode = MODE_ZERO;
      rem_next[1]     = '0;
    end else if (asum[1][EW-1:0] >= d) begin
      ctl_next.v_mode = MODE_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= ctl_next.valid;
    end
    if (en) begin
      ctl.face       <= ctl_next.face;
      ctl.degenerate <= ctl_next.degenerate;
      ctl.u_mode     <= ctl_next.u_mode;
      ctl.v_mode     <= ctl_next.v_mode;
      den2           <= d;
      rem            <= rem_next;
      quo            <= '0;
    end
  end

endmodule

// ===== design/cmf_cell.sv =====
module cmf_cell import cmf_pkg::*; #(
  parameter int COMP_BITS  = CMF_COMP_BITS,
  parameter int COORD_BITS = CMF_COORD_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  cmf_ctl_t                   ctl_in,
  input  logic [COMP_BITS:0]         den2_in,
  input  logic [1:0][COMP_BITS:0]    rem_in,
  input  logic [1:0][COORD_BITS-1:0] quo_in,
  output cmf_ctl_t                   ctl_out,
  output logic [COMP_BITS:0]         den2_out,
  output logic [1:0][COMP_BITS:0]    rem_out,
  output logic [1:0][COORD_BITS-1:0] quo_out
);

  localparam int RW = COMP_BITS + 1;

  logic [RW:0]               shl [2];
  logic [1:0]                take;
  logic [1:0][RW-1:0]        rem_next;
  logic [1:0][COORD_BITS-1:0] quo_next;

  // one restoring step per lane: shift, trial subtract, keep the quotient bit
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      shl[i]      = {rem_in[i], 1'b0};
      take[i]     = (shl[i] >= {1'b0, den2_in});
      rem_next[i] = take[i] ? RW'(shl[i] - {1'b0, den2_in}) : shl[i][RW-1:0];
      quo_next[i] = {quo_in[i][COORD_BITS-2:0], take[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.face       <= ctl_in.face;
      ctl_out.degenerate <= ctl_in.degenerate;
      ctl_out.u_mode     <= ctl_in.u_mode;
      ctl_out.v_mode     <= ctl_in.v_mode;
      den2_out           <= den2_in;
      rem_out            <= rem_next;
      quo_out            <= quo_next;
    end
  end

endmodule

// ===== design/cube_map_face_and_uv_select_core.sv =====
// Pipeline: one setup stage, one divider cell per coordinate bit and one output
// register lie between an accepted input word and its output word.
// Throughput: one word per cycle while the output is not stalled; each cell in
// the chain retires one quotient bit of u and of v, so the chain length sets the latency.
// Reset (rst, synchronous): clears all valid bits; payload is not reset.
`include "cube_map_face_and_uv_select_core_defines.svh"

module cube_map_face_and_uv_select_core import cmf_pkg::*; #(
  parameter int COMP_BITS  = CMF_COMP_BITS,
  parameter int COORD_BITS = CMF_COORD_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [COMP_BITS-1:0] dir_x,
  input  logic signed [COMP_BITS-1:0] dir_y,
  input  logic signed [COMP_BITS-1:0] dir_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [FACE_BITS-1:0]        face,
  output logic [COORD_BITS-1:0]       tex_u,
  output logic [COORD_BITS-1:0]       tex_v,
  output logic                        degenerate
);

  cmf_ctl_t                   ctl_s  [COORD_BITS+1];
  logic [COMP_BITS:0]         den2_s [COORD_BITS+1];
  logic [1:0][COMP_BITS:0]    rem_s  [COORD_BITS+1];
  logic [1:0][COORD_BITS-1:0] quo_s  [COORD_BITS+1];

  logic                  en;
  cmf_ctl_t              last;
  logic [COORD_BITS-1:0] u_next, v_next;

  // advance the whole chain unless a finished word is held at the output
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  cmf_front #(
    .COMP_BITS  (COMP_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .dir_x    (dir_x),
    .dir_y    (dir_y),
    .dir_z    (dir_z),
    .ctl      (ctl_s[0]),
    .den2     (den2_s[0]),
    .rem      (rem_s[0]),
    .quo      (quo_s[0])
  );

  for (genvar g = 0; g < COORD_BITS; g++) begin : g_cell
    cmf_cell #(
      .COMP_BITS  (COMP_BITS),
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (ctl_s[g]),
      .den2_in  (den2_s[g]),
      .rem_in   (rem_s[g]),
      .quo_in   (quo_s[g]),
      .ctl_out  (ctl_s[g+1]),
      .den2_out (den2_s[g+1]),
      .rem_out  (rem_s[g+1]),
      .quo_out  (quo_s[g+1])
    );
  end

  assign last = ctl_s[COORD_BITS];

  always_comb begin
    case (last.u_mode)
      MODE_DIV:  u_next = quo_s[COORD_BITS][0];
      MODE_MAX:  u_next = '1;
      MODE_ZERO: u_next = '0;
      default:   u_next = '0;
    endcase
    case (last.v_mode)
      MODE_DIV:  v_next = quo_s[COORD_BITS][1];
      MODE_MAX:  v_next = '1;
      MODE_ZERO: v_next = '0;
      default:   v_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      face       <= last.face;
      degenerate <= last.degenerate;
      tex_u      <= u_next;
      tex_v      <= v_next;
    end
  end

  `CMF_ASSERT_IMPLY(a_degen_zero_uv, clk, rst, out_valid && degenerate, tex_u == '0 && tex_v == '0)
  `CMF_ASSERT_IMPLY(a_degen_face, clk, rst, out_valid && degenerate, face == FACE_NEG_X)
  `CMF_ASSERT_NEVER(a_face_range, clk, rst, out_valid && face > FACE_NEG_Z)

endmodule
